FILE: rtl/pdd_pkg.sv
// ----------------------------------------------------------------------------
// pdd_pkg: shared types and constants of the deviation detector
// Fixed-point width and limits, stream widths, sequencer states, converter
// modes, configuration register indexes, table write strobes and fx_abs.
// ----------------------------------------------------------------------------
package pdd_pkg;

	// signed fixed point: mHz or volts, saturated to +-(2^47 - 1)
	localparam int FX_W = 48;
	localparam logic [FX_W-1:0] FX_MAX = 48'h7FFF_FFFF_FFFF;

	// radicand of the magnitude root: sum of two squares
	localparam int RAD_W = 2 * FX_W;

	// deviation scales
	localparam int LIM_W = 10;
	localparam logic [LIM_W-1:0] FREQ_SCALE = 10'd1000;
	localparam logic [LIM_W-1:0] VOL_SCALE = 10'd100;

	// stream payload widths
	localparam int S_DATA_W = 112;
	localparam int S_USER_W = 3;
	localparam int M_DATA_W = 8;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NOMINAL     = 2'd0,
		CFG_FREQ_LIMIT  = 2'd1,
		CFG_VOL_LIMIT   = 2'd2,
		CFG_INIT_WEIGHT = 2'd3
	} cfg_reg_t;

	// float converter modes
	typedef enum logic [1:0] {
		F2_ZERO,
		F2_SAT,
		F2_LEFT,
		F2_RIGHT
	} f2_kind_t;

	// frame sequencer
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CF,
		ST_CF_WAIT,
		ST_CA,
		ST_CA_WAIT,
		ST_CB,
		ST_CB_WAIT,
		ST_SQA,
		ST_SQA_WAIT,
		ST_SQB,
		ST_SQB_WAIT,
		ST_ROOT,
		ST_ROOT_WAIT,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SCAN_END,
		ST_READ,
		ST_NEW,
		ST_DEV0,
		ST_DEV1,
		ST_DEV2,
		ST_DEV3,
		ST_DECIDE,
		ST_UPD1,
		ST_UPD2,
		ST_UPD3,
		ST_NEXT,
		ST_DONE
	} state_t;

	// table write strobes
	typedef struct packed {
		logic new_entry;
		logic upd_freq;
		logic upd_vol;
	} mem_wr_t;

	function automatic logic [FX_W-1:0] fx_abs(input logic [FX_W-1:0] v);
		return v[FX_W-1] ? FX_W'(-v) : v;
	endfunction

endpackage

FILE: rtl/pdd_f2fix.sv
// ----------------------------------------------------------------------------
// pdd_f2fix: IEEE single to signed fixed point
// Decodes and registers the word at start, then aligns the mantissa one bit a cycle.
// Rounds to nearest, ties away from zero; saturates; NaN gives zero.
// ----------------------------------------------------------------------------
module pdd_f2fix
	import pdd_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [31:0]            word,
	input  logic                   mult1000,
	output logic                   done,
	output logic signed [FX_W-1:0] fix
);

	logic            busy_q;
	f2_kind_t        kind_q;
	logic [FX_W-1:0] sh_q;
	logic [5:0]      cnt_q;
	logic            ovf_q;
	logic            neg_q;

	logic [7:0]        ex;
	logic [7:0]        ee;
	logic [23:0]       mant;
	logic [33:0]       x;
	logic signed [9:0] k;
	logic signed [9:0] r;
	f2_kind_t          kind_d;
	logic [5:0]        cnt_d;
	logic [FX_W:0]     rnd;
	logic [FX_W-1:0]   mag;

	// decode
	always_comb begin
		ex   = word[30:23];
		ee   = (ex == 8'd0) ? 8'd1 : ex;
		mant = {ex != 8'd0, word[22:0]};
		x    = mult1000 ? (34'(mant) * 34'd1000) : 34'(mant);
		k    = $signed({2'b00, ee}) + $signed(10'(FRAC_BITS)) - 10'sd150;
		r    = -k;
		kind_d = F2_ZERO;
		cnt_d  = 6'd0;
		if (ex == 8'hFF) begin
			kind_d = (word[22:0] != 23'd0) ? F2_ZERO : F2_SAT;
		end else if (x == 34'd0) begin
			kind_d = F2_ZERO;
		end else if (k >= 10'sd0) begin
			if (k >= 10'sd47) begin
				kind_d = F2_SAT;
			end else begin
				kind_d = F2_LEFT;
				cnt_d  = k[5:0];
			end
		end else if (r > 10'sd40) begin
			kind_d = F2_ZERO;
		end else begin
			kind_d = F2_RIGHT;
			cnt_d  = 6'(r - 10'sd1);
		end
	end

	// one shift per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= cnt_d;
		end else if (busy_q) begin
			if (cnt_q == 6'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			kind_q <= kind_d;
			sh_q   <= FX_W'(x);
			ovf_q  <= 1'b0;
			neg_q  <= word[31];
		end else if (busy_q && cnt_q != 6'd0) begin
			if (kind_q == F2_LEFT) begin
				ovf_q <= ovf_q | sh_q[FX_W-2];
				sh_q  <= {sh_q[FX_W-2:0], 1'b0};
			end else begin
				sh_q <= {1'b0, sh_q[FX_W-1:1]};
			end
		end
	end

	// result
	always_comb begin
		rnd = ({1'b0, sh_q} + (FX_W+1)'(1)) >> 1;
		unique case (kind_q)
			F2_ZERO:  mag = '0;
			F2_SAT:   mag = FX_MAX;
			F2_LEFT:  mag = ovf_q ? FX_MAX : sh_q;
			F2_RIGHT: mag = rnd[FX_W-1:0];
			default:  mag = '0;
		endcase
		fix  = neg_q ? $signed(FX_W'(-mag)) : $signed(mag);
		done = busy_q && (cnt_q == 6'd0);
	end

endmodule

FILE: rtl/pdd_mul.sv
// ----------------------------------------------------------------------------
// pdd_mul: serial shift-and-add multiplier
// One multiplier bit per cycle; stops when the remaining bits are zero.
// ----------------------------------------------------------------------------
module pdd_mul #(
	parameter int AW = 49,
	parameter int BW = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             done,
	output logic [AW+BW-1:0] prod
);

	logic             busy_q;
	logic [AW+BW-1:0] acc_q;
	logic [AW+BW-1:0] mcand_q;
	logic [BW-1:0]    mplier_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// add shifted multiplicand where the low multiplier bit is set
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= (AW+BW)'(a);
			mplier_q <= b;
		end else if (busy_q && mplier_q != '0) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[AW+BW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[BW-1:1]};
		end
	end

	assign done = busy_q && (mplier_q == '0);
	assign prod = acc_q;

endmodule

FILE: rtl/pdd_div.sv
// ----------------------------------------------------------------------------
// pdd_div: restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module pdd_div #(
	parameter int NW = 80,
	parameter int DW = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   r2;
	logic          ge;

	always_comb begin
		r2 = {rem_q, quo_q[NW-1]};
		ge = r2 >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// numerator shifts out the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= ge ? DW'(r2 - {1'b0, den_q}) : DW'(r2);
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign quo  = quo_q;

endmodule

FILE: rtl/pdd_sqrt.sv
// ----------------------------------------------------------------------------
// pdd_sqrt: digit-by-digit integer square root
// Two radicand bits and one root bit per cycle; floor of the root.
// ----------------------------------------------------------------------------
module pdd_sqrt
	import pdd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RAD_W-1:0] rad,
	output logic             done,
	output logic [FX_W-1:0]  root
);

	localparam int CW = $clog2(FX_W + 1);

	logic             busy_q;
	logic [CW-1:0]    cnt_q;
	logic [RAD_W-1:0] rad_q;
	logic [FX_W+1:0]  rem_q;
	logic [FX_W-1:0]  root_q;
	logic [FX_W+3:0]  r2;
	logic [FX_W+3:0]  trial;
	logic             ge;

	// remainder stays below 2*root+1, so it needs two bits over the root
	always_comb begin
		r2    = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
		trial = {2'b00, root_q, 2'b01};
		ge    = r2 >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(FX_W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? (FX_W+2)'(r2 - trial) : (FX_W+2)'(r2);
			root_q <= {root_q[FX_W-2:0], ge};
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign root = root_q;

endmodule

FILE: rtl/pmu_deviation_detector.sv
// ----------------------------------------------------------------------------
// pmu_deviation_detector: per-station frequency and voltage deviation check
// One measurement frame in on the s_ stream, one flag byte out on m_ stream.
// Frequency and voltage magnitude are kept as running means per station in
// a small table; a quantity that strays beyond its configured limit is flagged,
// otherwise its mean is updated; a frequency deviation skips the voltage check.
// Frames are handled one at a time. From acceptance to result a frame passes
// through float alignment of each float word, two serial squares and a root
// for rectangular phasors, a table scan of every entry, then per checked
// quantity up to two serial multiplies and, on update, a multiply and a
// division. The serial units work one bit per cycle; the sequencer returns
// to idle once the result is registered.
// s_tready is high only while no frame is in work; a finished result sits in
// an output register, so the next frame is taken while m_tvalid waits; if the
// receiver stalls, the following frame holds at its end until the register
// frees. Reset empties the table (all entries invalid) and loads the
// configuration defaults. The config channel is always ready and must be
// written only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module pmu_deviation_detector
	import pdd_pkg::*;
#(
	parameter int STATIONS    = 16,
	parameter int WEIGHT_BITS = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// frame: station_id, freq_word, phasor_first, phasor_second
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,
	// freq_is_float, phasor_is_float, phasor_is_polar
	input  logic [S_USER_W-1:0]   s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// frame_ok, freq_attack, vol_attack, new_station, table_full, zero pad
	output logic [M_DATA_W-1:0]   m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IW  = (STATIONS > 1) ? $clog2(STATIONS) : 1;
	localparam int WB  = WEIGHT_BITS;
	localparam int AW  = FX_W + 1;
	localparam int MBW = (WB > FX_W) ? WB : FX_W;
	localparam int PW  = AW + MBW;
	localparam int NW  = FX_W + WB;
	localparam int DW  = WB + 1;

	// configuration
	logic [16:0] nominal_q;
	logic [9:0]  freq_lim_q;
	logic [6:0]  vol_lim_q;
	logic [15:0] init_w_q;

	// control
	state_t        state_q, state_d;
	logic [STATIONS-1:0] valid_q;
	logic          out_valid_q;
	logic [IW-1:0] addr_q;
	logic          hit_q, free_q, sel_q;

	// frame payload
	logic [15:0]            sid_q;
	logic [31:0]            fw_q, pa_q, pb_q;
	logic                   ff_q, pf_q, pp_q;
	logic signed [FX_W-1:0] cf_q, a_q, b_q, cv_q;
	logic [RAD_W-1:0]       sq_q;
	logic [IW-1:0]          hit_idx_q, free_idx_q;
	logic [PW-1:0]          t_q;
	logic signed [NW:0]     s_q;
	logic                   dev_q, fa_q, va_q, nw_q, full_q;
	logic [M_DATA_W-1:0]    out_data_q;

	// table
	logic [15:0]   id_mem [STATIONS];
	logic [FX_W-1:0] fm_mem [STATIONS];
	logic [WB-1:0] fw_mem [STATIONS];
	logic [FX_W-1:0] vm_mem [STATIONS];
	logic [WB-1:0] vw_mem [STATIONS];
	logic [15:0]   rd_id_q;
	logic [FX_W-1:0] rd_fm_q, rd_vm_q;
	logic [WB-1:0] rd_fw_q, rd_vw_q;

	// unit handshakes
	logic                   f2_start, f2_done, f2_mult;
	logic [31:0]            f2_word;
	logic signed [FX_W-1:0] f2_fix;
	logic                   mul_start, mul_done;
	logic [AW-1:0]          mul_a;
	logic [MBW-1:0]         mul_b;
	logic [PW-1:0]          mul_prod;
	logic                   div_start, div_done;
	logic [NW-1:0]          div_num, div_quo;
	logic [DW-1:0]          div_den;
	logic                   rt_start, rt_done;
	logic [FX_W-1:0]        rt_root;
	mem_wr_t                mem_wr;

	// derived values
	logic signed [18:0]     fsum;
	logic signed [FX_W-1:0] cf_int, pa_int, pb_int;
	logic [FX_W-1:0]        cur_m, cur_c, new_mean, qsat, root_sat, m_mag;
	logic [WB-1:0]          cur_w;
	logic [LIM_W-1:0]       cur_lim, cur_scale;
	logic signed [FX_W:0]   diff;
	logic [FX_W:0]          ad;
	logic                   m_pos, m_zero, w_max, scan_hit, scan_free, last;
	logic signed [NW:0]     prod_s, s_sum;
	logic [NW:0]            s_abs;

	// --------------------------------------------------------------------
	// operand preparation
	always_comb begin
		fsum   = $signed({2'b00, nominal_q}) + $signed({{3{fw_q[15]}}, fw_q[15:0]});
		cf_int = $signed({{(FX_W-19){fsum[18]}}, fsum}) <<< FRAC_BITS;
		pa_int = $signed({{(FX_W-16){pa_q[15]}}, pa_q[15:0]}) <<< FRAC_BITS;
		pb_int = $signed({{(FX_W-16){pb_q[15]}}, pb_q[15:0]}) <<< FRAC_BITS;

		cur_m     = sel_q ? rd_vm_q : rd_fm_q;
		cur_w     = sel_q ? rd_vw_q : rd_fw_q;
		cur_c     = sel_q ? cv_q : cf_q;
		cur_lim   = sel_q ? LIM_W'(vol_lim_q) : freq_lim_q;
		cur_scale = sel_q ? VOL_SCALE : FREQ_SCALE;
		m_mag     = fx_abs(cur_m);
		m_zero    = (cur_m == '0);
		m_pos     = !cur_m[FX_W-1] && !m_zero;
		w_max     = &cur_w;

		diff = $signed({cur_c[FX_W-1], cur_c}) - $signed({cur_m[FX_W-1], cur_m});
		ad   = diff[FX_W] ? (FX_W+1)'(-diff) : (FX_W+1)'(diff);

		// signed numerator of the mean update
		prod_s = $signed({1'b0, mul_prod[NW-1:0]});
		s_sum  = (cur_m[FX_W-1] ? -prod_s : prod_s)
			+ $signed({{(NW+1-FX_W){cur_c[FX_W-1]}}, cur_c});
		s_abs  = s_q[NW] ? (NW+1)'(-s_q) : (NW+1)'(s_q);

		qsat     = (div_quo > NW'(FX_MAX)) ? FX_MAX : div_quo[FX_W-1:0];
		new_mean = s_q[NW] ? FX_W'(-qsat) : qsat;
		root_sat = (rt_root > FX_MAX) ? FX_MAX : rt_root;

		scan_hit  = valid_q[addr_q] && (rd_id_q == sid_q) && !hit_q;
		scan_free = !valid_q[addr_q] && !free_q;
		last      = (addr_q == IW'(STATIONS - 1));
	end

	// --------------------------------------------------------------------
	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (s_tvalid) state_d = ST_CF;
			ST_CF:        state_d = ff_q ? ST_CF_WAIT : ST_CA;
			ST_CF_WAIT:   if (f2_done) state_d = ST_CA;
			ST_CA: begin
				if (pf_q) state_d = ST_CA_WAIT;
				else state_d = pp_q ? ST_SCAN_RD : ST_CB;
			end
			ST_CA_WAIT:   if (f2_done) state_d = pp_q ? ST_SCAN_RD : ST_CB;
			ST_CB:        state_d = pf_q ? ST_CB_WAIT : ST_SQA;
			ST_CB_WAIT:   if (f2_done) state_d = ST_SQA;
			ST_SQA:       state_d = ST_SQA_WAIT;
			ST_SQA_WAIT:  if (mul_done) state_d = ST_SQB;
			ST_SQB:       state_d = ST_SQB_WAIT;
			ST_SQB_WAIT:  if (mul_done) state_d = ST_ROOT;
			ST_ROOT:      state_d = ST_ROOT_WAIT;
			ST_ROOT_WAIT: if (rt_done) state_d = ST_SCAN_RD;
			ST_SCAN_RD:   state_d = ST_SCAN_CMP;
			ST_SCAN_CMP:  state_d = last ? ST_SCAN_END : ST_SCAN_RD;
			ST_SCAN_END: begin
				priority if (hit_q) state_d = ST_READ;
				else if (free_q) state_d = ST_NEW;
				else state_d = ST_DONE;
			end
			ST_READ:      state_d = ST_DEV0;
			ST_NEW:       state_d = ST_DONE;
			ST_DEV0:      state_d = m_pos ? ST_DEV1 : ST_DECIDE;
			ST_DEV1:      if (mul_done) state_d = ST_DEV2;
			ST_DEV2:      state_d = ST_DEV3;
			ST_DEV3:      if (mul_done) state_d = ST_DECIDE;
			ST_DECIDE: begin
				priority if (dev_q) state_d = ST_DONE;
				else if (w_max) state_d = ST_NEXT;
				else state_d = ST_UPD1;
			end
			ST_UPD1:      if (mul_done) state_d = ST_UPD2;
			ST_UPD2:      state_d = ST_UPD3;
			ST_UPD3:      if (div_done) state_d = ST_NEXT;
			ST_NEXT:      state_d = sel_q ? ST_DONE : ST_DEV0;
			ST_DONE:      if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// --------------------------------------------------------------------
	// sequencer outputs
	always_comb begin
		f2_start  = 1'b0;
		f2_word   = fw_q;
		f2_mult   = 1'b0;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = s_abs[NW-1:0];
		div_den   = DW'(cur_w) + DW'(1);
		rt_start  = 1'b0;
		mem_wr    = '0;
		unique case (state_q)
			ST_CF: begin
				f2_start = ff_q;
				f2_mult  = 1'b1;
			end
			ST_CA: begin
				f2_start = pf_q;
				f2_word  = pa_q;
			end
			ST_CB: begin
				f2_start = pf_q;
				f2_word  = pb_q;
			end
			ST_SQA: begin
				mul_start = 1'b1;
				mul_a     = AW'(fx_abs(a_q));
				mul_b     = MBW'(fx_abs(a_q));
			end
			ST_SQB: begin
				mul_start = 1'b1;
				mul_a     = AW'(fx_abs(b_q));
				mul_b     = MBW'(fx_abs(b_q));
			end
			ST_ROOT:  rt_start = 1'b1;
			ST_NEW:   mem_wr.new_entry = 1'b1;
			ST_DEV0: begin
				mul_start = m_pos;
				mul_a     = ad;
				mul_b     = MBW'(cur_scale);
			end
			ST_DEV2: begin
				mul_start = 1'b1;
				mul_a     = AW'(cur_m);
				mul_b     = MBW'(cur_lim);
			end
			ST_DECIDE: begin
				mul_start = !dev_q && !w_max;
				mul_a     = AW'(m_mag);
				mul_b     = MBW'(cur_w);
			end
			ST_UPD2:  div_start = 1'b1;
			ST_UPD3: begin
				mem_wr.upd_freq = div_done && !sel_q;
				mem_wr.upd_vol  = div_done && sel_q;
			end
			default: ;
		endcase
	end

	// --------------------------------------------------------------------
	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			addr_q      <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			sel_q       <= 1'b0;
			nominal_q   <= 17'd50000;
			freq_lim_q  <= 10'd9;
			vol_lim_q   <= 7'd5;
			init_w_q    <= 16'd500;
		end else begin
			state_q <= state_d;

			if (cfg_valid) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_NOMINAL:     nominal_q  <= cfg_data;
					CFG_FREQ_LIMIT:  freq_lim_q <= cfg_data[9:0];
					CFG_VOL_LIMIT:   vol_lim_q  <= cfg_data[6:0];
					CFG_INIT_WEIGHT: init_w_q   <= cfg_data[15:0];
					default: ;
				endcase
			end

			// frame start
			if (state_q == ST_IDLE && s_tvalid) begin
				addr_q <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				sel_q  <= 1'b0;
			end

			// table scan
			if (state_q == ST_SCAN_CMP) begin
				if (scan_hit) hit_q <= 1'b1;
				if (scan_free) free_q <= 1'b1;
				if (!last) addr_q <= addr_q + IW'(1);
			end
			if (state_q == ST_SCAN_END) begin
				addr_q <= hit_q ? hit_idx_q : free_idx_q;
			end
			if (mem_wr.new_entry) valid_q[addr_q] <= 1'b1;
			if (state_q == ST_NEXT) sel_q <= 1'b1;

			// output register
			if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// --------------------------------------------------------------------
	// frame datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					sid_q  <= s_tdata[15:0];
					fw_q   <= s_tdata[47:16];
					pa_q   <= s_tdata[79:48];
					pb_q   <= s_tdata[111:80];
					ff_q   <= s_tuser[0];
					pf_q   <= s_tuser[1];
					pp_q   <= s_tuser[2];
					fa_q   <= 1'b0;
					va_q   <= 1'b0;
					nw_q   <= 1'b0;
					full_q <= 1'b0;
				end
			end
			ST_CF:       if (!ff_q) cf_q <= cf_int;
			ST_CF_WAIT:  if (f2_done) cf_q <= f2_fix;
			ST_CA: begin
				if (!pf_q) begin
					a_q  <= pa_int;
					cv_q <= pa_int;
				end
			end
			ST_CA_WAIT: begin
				if (f2_done) begin
					a_q  <= f2_fix;
					cv_q <= f2_fix;
				end
			end
			ST_CB:       if (!pf_q) b_q <= pb_int;
			ST_CB_WAIT:  if (f2_done) b_q <= f2_fix;
			ST_SQA_WAIT: if (mul_done) sq_q <= mul_prod[RAD_W-1:0];
			ST_SQB_WAIT: if (mul_done) sq_q <= sq_q + mul_prod[RAD_W-1:0];
			ST_ROOT_WAIT: if (rt_done) cv_q <= root_sat;
			ST_SCAN_CMP: begin
				if (scan_hit) hit_idx_q <= addr_q;
				if (scan_free) free_idx_q <= addr_q;
			end
			ST_SCAN_END: if (!hit_q && !free_q) full_q <= 1'b1;
			ST_NEW:      nw_q <= 1'b1;
			ST_DEV0:     if (!m_pos) dev_q <= m_zero && (ad != '0);
			ST_DEV1:     if (mul_done) t_q <= mul_prod;
			ST_DEV3:     if (mul_done) dev_q <= t_q > mul_prod;
			ST_DECIDE: begin
				if (dev_q) begin
					if (sel_q) va_q <= 1'b1;
					else fa_q <= 1'b1;
				end
			end
			ST_UPD1:     if (mul_done) s_q <= s_sum;
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_data_q <= {3'b000, full_q, nw_q, va_q, fa_q, !(fa_q || va_q)};
				end
			end
			default: ;
		endcase
	end

	// --------------------------------------------------------------------
	// station table: one write port, registered read at addr_q
	always_ff @(posedge clk) begin
		if (mem_wr.new_entry) begin
			id_mem[addr_q] <= sid_q;
			fm_mem[addr_q] <= FX_W'({1'b0, nominal_q}) << FRAC_BITS;
			fw_mem[addr_q] <= WB'(init_w_q);
			vm_mem[addr_q] <= cv_q;
			vw_mem[addr_q] <= WB'(init_w_q);
		end
		if (mem_wr.upd_freq) begin
			fm_mem[addr_q] <= new_mean;
			fw_mem[addr_q] <= cur_w + WB'(1);
		end
		if (mem_wr.upd_vol) begin
			vm_mem[addr_q] <= new_mean;
			vw_mem[addr_q] <= cur_w + WB'(1);
		end
		rd_id_q <= id_mem[addr_q];
		rd_fm_q <= fm_mem[addr_q];
		rd_fw_q <= fw_mem[addr_q];
		rd_vm_q <= vm_mem[addr_q];
		rd_vw_q <= vw_mem[addr_q];
	end

	// --------------------------------------------------------------------
	// serial units
	pdd_f2fix #(
		.FRAC_BITS(FRAC_BITS)
	) u_f2fix (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (f2_start),
		.word     (f2_word),
		.mult1000 (f2_mult),
		.done     (f2_done),
		.fix      (f2_fix)
	);

	pdd_mul #(
		.AW(AW),
		.BW(MBW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	pdd_div #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	pdd_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rt_start),
		.rad    (sq_q),
		.done   (rt_done),
		.root   (rt_root)
	);

	// ports
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

endmodule
